### hdl/d2i_pkg.sv
// ----------------------------------------------------------------------------
// d2i_pkg: shared types and constants for the double to int32 converter
// Holds the stage-to-stage record types and the rounding mode codes.
// ----------------------------------------------------------------------------
package d2i_pkg;

  localparam int unsigned ExpW  = 11;
  localparam int unsigned FracW = 52;
  localparam logic [ExpW-1:0] ExpBias = 11'd1023;
  localparam logic [ExpW-1:0] ExpMax  = 11'h7ff;

  // Configuration register indexes.
  localparam logic CfgMode = 1'b0;
  localparam logic CfgInv  = 1'b1;

  typedef enum logic [1:0] {
    RM_NEAREST = 2'd0,
    RM_ZERO    = 2'd1,
    RM_PINF    = 2'd2,
    RM_MINF    = 2'd3
  } rmode_e;

  // Stage 1 -> stage 2: unpacked operand and early classification.
  typedef struct packed {
    logic            neg;
    rmode_e          mode;
    logic            is_nan;
    logic            snan;
    logic            big;       // infinity, NaN or exponent above 31
    logic            below_one; // exponent below 1023 (includes zero/denormal)
    logic            half_cmp;  // below_one: value at or above one half
    logic            half_eq;   // below_one: exactly one half
    logic            val_nz;    // magnitude is not zero
    logic [5:0]      sh;        // right shift, valid when not below_one/big
    logic [FracW:0]  mant;
  } s1_t;

  // Stage 2 -> stage 3: integer part and rounding information.
  typedef struct packed {
    logic        neg;
    rmode_e      mode;
    logic        is_nan;
    logic        snan;
    logic        big;
    logic [32:0] ip;
    logic        inexact;
    logic [1:0]  cmp;       // 0 below, 1 equal, 2 above one half
  } s2_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic        write_result;
    logic        fraction_inexact;
    logic        fraction_rounded;
    logic        raise_signaling_nan;
    logic        raise_invalid_convert;
    logic        raise_inexact;
  } res_t;

  localparam logic [1:0] CmpLo = 2'd0;
  localparam logic [1:0] CmpEq = 2'd1;
  localparam logic [1:0] CmpHi = 2'd2;

endpackage

### hdl/d2i_shift.sv
// ----------------------------------------------------------------------------
// d2i_shift: alignment stage
// Shifts the mantissa right and classifies the remainder against one half.
// ----------------------------------------------------------------------------
module d2i_shift import d2i_pkg::*; (
  input  s1_t s1_i,
  output s2_t s2_o
);
  logic [FracW:0] rem_mask;
  logic [FracW:0] rem;
  logic [FracW:0] half;
  logic [FracW:0] ip_full;

  always_comb begin
    ip_full  = s1_i.mant >> s1_i.sh;
    rem_mask = ~({(FracW+1){1'b1}} << s1_i.sh);
    rem      = s1_i.mant & rem_mask;
    half     = {{FracW{1'b0}}, 1'b1} << (s1_i.sh - 6'd1);
    s2_o.neg    = s1_i.neg;
    s2_o.mode   = s1_i.mode;
    s2_o.is_nan = s1_i.is_nan;
    s2_o.snan   = s1_i.snan;
    s2_o.big    = s1_i.big;
    if (s1_i.below_one) begin
      // any nonzero magnitude below one leaves a fraction behind
      s2_o.ip      = '0;
      s2_o.inexact = s1_i.val_nz;
      s2_o.cmp     = !s1_i.half_cmp ? CmpLo : (s1_i.half_eq ? CmpEq : CmpHi);
    end else begin
      s2_o.ip      = ip_full[32:0];
      s2_o.inexact = rem != '0;
      s2_o.cmp     = (rem < half) ? CmpLo : ((rem == half) ? CmpEq : CmpHi);
    end
  end
endmodule

### hdl/d2i_round.sv
// ----------------------------------------------------------------------------
// d2i_round: rounding and result packing stage
// Saturates, rounds in the selected mode and builds the destination word.
// ----------------------------------------------------------------------------
module d2i_round import d2i_pkg::*; (
  input  s2_t  s2_i,
  input  logic invalid_enable_i,
  output res_t res_o
);
  logic        exc;
  logic        up;
  logic [31:0] mag;
  logic [31:0] value;
  logic        wr;

  always_comb begin
    exc   = 1'b0;
    up    = 1'b0;
    value = '0;
    mag   = '0;
    if (s2_i.is_nan) begin
      value = 32'h8000_0000;
      exc   = 1'b1;
    end else if (s2_i.big) begin
      value = s2_i.neg ? 32'h8000_0000 : 32'h7fff_ffff;
      exc   = 1'b1;
    end else if (!s2_i.neg && (s2_i.ip > 33'h07fff_ffff ||
                 (s2_i.ip == 33'h07fff_ffff && s2_i.inexact))) begin
      value = 32'h7fff_ffff;
      exc   = 1'b1;
    end else if (s2_i.neg && (s2_i.ip > 33'h08000_0000 ||
                 (s2_i.ip == 33'h08000_0000 && s2_i.inexact))) begin
      value = 32'h8000_0000;
      exc   = 1'b1;
    end else begin
      if (s2_i.inexact) begin
        case (s2_i.mode)
          RM_NEAREST: up = s2_i.cmp == CmpHi || (s2_i.cmp == CmpEq && s2_i.ip[0]);
          RM_PINF:    up = !s2_i.neg;
          RM_MINF:    up = s2_i.neg;
          default:    up = 1'b0;
        endcase
      end
      mag   = s2_i.ip[31:0] + {31'd0, up};
      value = s2_i.neg ? (32'd0 - mag) : mag;
    end
    wr = !exc || !invalid_enable_i;
    res_o.result_bits = '0;
    if (wr) begin
      res_o.result_bits = {32'hfff8_0000, value};
      res_o.result_bits[32] = (value == '0) && s2_i.neg;
    end
    res_o.write_result          = wr;
    res_o.fraction_inexact      = s2_i.inexact && !exc;
    res_o.fraction_rounded      = up && !exc;
    res_o.raise_signaling_nan   = s2_i.snan;
    res_o.raise_invalid_convert = exc;
    res_o.raise_inexact         = s2_i.inexact && !exc;
  end
endmodule

### hdl/double_to_int32_convert.sv
// ----------------------------------------------------------------------------
// double_to_int32_convert: IEEE binary64 to signed int32 conversion
// Three-stage pipeline: unpack, align, round and pack.
// ----------------------------------------------------------------------------
// Accepts one transaction per cycle when the output is not stalled and
// registers each one in stages 1, 2 and 3 in turn. Stage 1 unpacks the
// operand and classifies NaN, infinity and range; stage 2 aligns the
// mantissa with a barrel shift; stage 3 rounds, saturates and packs the
// destination word and the exception flags. Each stage holds its own valid
// bit; a stall on the output freezes only stages that are full, so bubbles
// collapse. Write configuration only while no transaction is in flight.
module double_to_int32_convert import d2i_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] operand_bits_i,
  input  logic        toward_zero_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_bits_o,
  output logic        write_result_o,
  output logic        fraction_inexact_o,
  output logic        fraction_rounded_o,
  output logic        raise_signaling_nan_o,
  output logic        raise_invalid_convert_o,
  output logic        raise_inexact_o
);
  rmode_e mode_q;
  logic   inv_en_q;

  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  res_t res_d, res_q;
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= RM_NEAREST;
      inv_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgMode) mode_q <= rmode_e'(cfg_data_i);
      if (cfg_index_i == CfgInv)  inv_en_q <= cfg_data_i[0];
    end
  end

  // Advance a stage when its successor is empty or moving.
  assign adv3 = !v3_q || !out_stall_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_stall_o = !adv1;

  // Stage 1: unpack and classify.
  logic [ExpW-1:0]  expo;
  logic [FracW-1:0] frac;
  logic [ExpW-1:0]  eoff;
  always_comb begin
    expo = operand_bits_i[62:52];
    frac = operand_bits_i[51:0];
    eoff = expo - ExpBias;
    s1_d.neg       = operand_bits_i[63];
    s1_d.mode      = toward_zero_i ? RM_ZERO : mode_q;
    s1_d.is_nan    = (expo == ExpMax) && (frac != '0);
    s1_d.snan      = s1_d.is_nan && !frac[51];
    s1_d.big       = (expo == ExpMax) || (expo >= ExpBias && eoff > 11'd31);
    s1_d.below_one = expo < ExpBias;
    s1_d.half_cmp  = expo == (ExpBias - 11'd1);
    s1_d.half_eq   = frac == '0;
    s1_d.val_nz    = (expo != '0) || (frac != '0);
    s1_d.sh        = 6'd52 - eoff[5:0];
    s1_d.mant      = {1'b1, frac};
  end

  d2i_shift u_shift (.s1_i(s1_q), .s2_o(s2_d));
  d2i_round u_round (.s2_i(s2_q), .invalid_enable_i(inv_en_q), .res_o(res_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // Payload registers: load only when the stage advances.
  always_ff @(posedge clk_i) begin
    if (adv1) s1_q  <= s1_d;
    if (adv2) s2_q  <= s2_d;
    if (adv3) res_q <= res_d;
  end

  assign out_valid_o             = v3_q;
  assign result_bits_o           = res_q.result_bits;
  assign write_result_o          = res_q.write_result;
  assign fraction_inexact_o      = res_q.fraction_inexact;
  assign fraction_rounded_o      = res_q.fraction_rounded;
  assign raise_signaling_nan_o   = res_q.raise_signaling_nan;
  assign raise_invalid_convert_o = res_q.raise_invalid_convert;
  assign raise_inexact_o         = res_q.raise_inexact;

  // A held result stays put while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_bits_o))
    else $error("stalled result changed");
  // Rounding up never happens on an exception.
  a_fr_exc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(fraction_rounded_o && raise_invalid_convert_o))
    else $error("FR with invalid");
  // Result word is suppressed only on an exception.
  a_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_result_o |-> raise_invalid_convert_o)
    else $error("write dropped without exception");
endmodule
